>>> src/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int TIME_W            = 31;
    localparam int SLOT_ID_W         = 6;
    localparam int FIRES_W           = 16;
    localparam int SLOTS_DEFAULT     = 16;
    localparam int MAX_FIRES_DEFAULT = 63;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;
    localparam logic [1:0] KIND_FIRE  = 2'd3;

    localparam logic [1:0] CELL_NOP    = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [SLOT_ID_W-1:0] slot;
        logic [TIME_W-1:0]    due;
    } entry_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [SLOT_ID_W-1:0] slot;
        logic [TIME_W-1:0]    due;
    } cell_cmd_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/sorted_periodic_timer_queue.sv
// Sorted periodic timer queue.
// The s_ channel takes one command item: tuser carries the operation (alloc,
// start, stop, release, tick) and tdata the slot, period and current time.
// The m_ channel returns result items; tlast marks the final result of a
// command. Alloc, start, stop, release and unknown operations give one item.
// A tick gives one item per timer fire, oldest due time first, or a single
// acknowledge when nothing is due.
// Armed timers sit in a row of cells kept sorted by due time; an insert or a
// removal shifts the whole row together, each cell registering its new entry.
// A command is registered when taken and executed in the execute state, and
// its single result is registered in the output register. A tick is decoded
// first; per fire the block pops the head cell and then re-inserts it with
// the new due time, and a final step emits the last item.
// The next command is taken once the previous one has finished.
// A stalled receiver holds the output register and the block waits with it.
// Reset is synchronous; it frees all slots and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module sorted_periodic_timer_queue #(
    parameter int SLOTS              = stq_pkg::SLOTS_DEFAULT,
    parameter int MAX_FIRES_PER_TICK = stq_pkg::MAX_FIRES_DEFAULT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,  // slot[3:0], period[34:4], now_time[65:35], zero
    input  wire  [2:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,  // result_slot[3:0], fire_count[19:4],
                                  // due_time[50:20], more_pending[51], zero
    output logic [1:0]  m_tuser,  // result_kind
    output logic        m_tlast
);
    import stq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(MAX_FIRES_PER_TICK + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;
    localparam logic [1:0] ST_INS  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        op_reg;
    logic [3:0]        slot_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] now_reg;

    logic [SLOTS-1:0]  used_reg, used_next;
    logic [SLOTS-1:0]  armed_reg, armed_next;
    logic [TIME_W-1:0] period_mem [SLOTS];
    logic [FIRES_W-1:0] fires_mem [SLOTS];

    logic [NW-1:0]      n_reg, n_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IW-1:0]      pend_slot_reg;
    logic [FIRES_W-1:0] pend_fires_reg;
    logic [TIME_W-1:0]  pend_due_reg;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [1:0]         out_kind_reg;
    logic [3:0]         out_slot_reg;
    logic [FIRES_W-1:0] out_fires_reg;
    logic [TIME_W-1:0]  out_due_reg;
    logic               out_more_reg;
    logic               out_last_reg;

    logic               load_out;
    logic [1:0]         load_kind;
    logic [3:0]         load_slot;
    logic [FIRES_W-1:0] load_fires;
    logic [TIME_W-1:0]  load_due;
    logic               load_more;
    logic               load_last;

    logic               wr_period;
    logic [IW-1:0]      wr_period_idx;
    logic               wr_fires;
    logic [IW-1:0]      wr_fires_idx;
    logic [FIRES_W-1:0] wr_fires_val;
    logic               take_pend;

    cell_cmd_t          cmd;
    entry_t             head;
    logic [SLOTS-1:0]   chain_valid;

    logic               out_free;
    logic [IW-1:0]      s_idx;
    logic               in_range;
    logic               free_found;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      head_idx;
    logic               head_due;
    logic               can_fire;

    stq_chain #(.SLOTS(SLOTS)) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .head      (head),
        .valid_vec (chain_valid)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_idx    = IW'(slot_reg);
    assign in_range = (32'(slot_reg) < SLOTS);
    assign head_idx = IW'(head.slot);
    assign head_due = head.valid && (head.due <= now_reg);
    assign can_fire = head_due && (n_reg < NW'(MAX_FIRES_PER_TICK));

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (!free_found && !used_reg[k]) begin
                free_found = 1'b1;
                free_idx   = IW'(k);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        armed_next      = armed_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        load_out        = 1'b0;
        load_kind       = KIND_ACK;
        load_slot       = '0;
        load_fires      = '0;
        load_due        = '0;
        load_more       = 1'b0;
        load_last       = 1'b1;
        wr_period       = 1'b0;
        wr_period_idx   = free_idx;
        wr_fires        = 1'b0;
        wr_fires_idx    = free_idx;
        wr_fires_val    = '0;
        take_pend       = 1'b0;
        cmd.op          = CELL_NOP;
        cmd.slot        = SLOT_ID_W'(s_idx);
        cmd.due         = sat_add(now_reg, period_mem[s_idx]);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    load_out   = 1'b1;
                    case (op_reg)
                        OP_ALLOC: begin
                            if (free_found) begin
                                used_next[free_idx]  = 1'b1;
                                armed_next[free_idx] = 1'b0;
                                wr_period            = 1'b1;
                                wr_fires             = 1'b1;
                                load_kind            = KIND_ALLOC;
                                load_slot            = 4'(free_idx);
                            end else begin
                                load_kind = KIND_FULL;
                            end
                        end
                        OP_START: begin
                            if (in_range && used_reg[s_idx] && !armed_reg[s_idx]) begin
                                armed_next[s_idx] = 1'b1;
                                cmd.op            = CELL_INSERT;
                            end
                        end
                        OP_STOP: begin
                            if (in_range && armed_reg[s_idx]) begin
                                armed_next[s_idx] = 1'b0;
                                cmd.op            = CELL_REMOVE;
                            end
                        end
                        OP_RELEASE: begin
                            if (in_range && used_reg[s_idx]) begin
                                if (armed_reg[s_idx]) begin
                                    cmd.op = CELL_REMOVE;
                                end
                                armed_next[s_idx] = 1'b0;
                                used_next[s_idx]  = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            load_out        = 1'b0;
                            state_next      = ST_TICK;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: begin
                            load_kind = KIND_ACK;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    load_out = pend_valid_reg || !can_fire;
                    if (pend_valid_reg) begin
                        load_kind  = KIND_FIRE;
                        load_slot  = 4'(pend_slot_reg);
                        load_fires = pend_fires_reg;
                        load_due   = pend_due_reg;
                        load_last  = !can_fire;
                        load_more  = !can_fire && head_due;
                    end
                    if (can_fire) begin
                        take_pend       = 1'b1;
                        pend_valid_next = 1'b1;
                        wr_fires        = 1'b1;
                        wr_fires_idx    = head_idx;
                        wr_fires_val    = fires_mem[head_idx] + 1'b1;
                        n_next          = n_reg + 1'b1;
                        cmd.op          = CELL_REMOVE;
                        cmd.slot        = head.slot;
                        state_next      = ST_INS;
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_INS: begin
                cmd.op     = CELL_INSERT;
                cmd.slot   = SLOT_ID_W'(pend_slot_reg);
                cmd.due    = sat_add(pend_due_reg, period_mem[pend_slot_reg]);
                state_next = ST_TICK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            armed_reg      <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            armed_reg      <= armed_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            slot_reg   <= s_tdata[3:0];
            period_reg <= s_tdata[34:4];
            now_reg    <= s_tdata[65:35];
        end
        if (wr_period) begin
            period_mem[wr_period_idx] <= period_reg;
        end
        if (wr_fires) begin
            fires_mem[wr_fires_idx] <= wr_fires_val;
        end
        if (take_pend) begin
            pend_slot_reg  <= head_idx;
            pend_fires_reg <= wr_fires_val;
            pend_due_reg   <= head.due;
        end
        if (load_out) begin
            out_kind_reg  <= load_kind;
            out_slot_reg  <= load_slot;
            out_fires_reg <= load_fires;
            out_due_reg   <= load_due;
            out_more_reg  <= load_more;
            out_last_reg  <= load_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_more_reg, out_due_reg, out_fires_reg, out_slot_reg};

`ifndef SYNTHESIS
    a_queue_matches_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(armed_reg) == $countones(chain_valid)))
        else $error("queue contents differ from armed slots");

    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) |-> (n_reg <= NW'(MAX_FIRES_PER_TICK)))
        else $error("fire count beyond the per-tick limit");

    a_pend_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> ((state_reg == ST_TICK) || (state_reg == ST_INS)))
        else $error("pending fire outside a tick");

    a_ins_has_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS) |-> pend_valid_reg)
        else $error("re-insert without a pending fire");
`endif

endmodule

`default_nettype wire

>>> src/stq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire stq_pkg::cell_cmd_t cmd,
    input  wire stq_pkg::entry_t    prev_entry,
    input  wire                 prev_le,
    input  wire                 prev_hit,
    input  wire stq_pkg::entry_t    next_entry,
    output stq_pkg::entry_t     entry,
    output logic                le,
    output logic                hit
);
    import stq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign le    = entry_reg.valid && (entry_reg.due <= cmd.due);
    assign hit   = prev_hit || (entry_reg.valid && (entry_reg.slot == cmd.slot));

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (!prev_le) begin
                    entry_next = prev_entry;
                end else if (!le) begin
                    entry_next.valid = 1'b1;
                    entry_next.slot  = cmd.slot;
                    entry_next.due   = cmd.due;
                end
            end
            CELL_REMOVE: begin
                if (hit) begin
                    entry_next = next_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

>>> src/stq_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module stq_chain #(
    parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire stq_pkg::cell_cmd_t cmd,
    output stq_pkg::entry_t     head,
    output logic [SLOTS-1:0]    valid_vec
);
    import stq_pkg::*;

    entry_t entries [SLOTS];
    logic   le_vec  [SLOTS];
    logic   hit_vec [SLOTS];

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++) begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_l;
            logic   prev_h;
            if (i == 0) begin : g_first
                assign prev_e = '0;
                assign prev_l = 1'b1;
                assign prev_h = 1'b0;
            end else begin : g_mid
                assign prev_e = entries[i-1];
                assign prev_l = le_vec[i-1];
                assign prev_h = hit_vec[i-1];
            end
            if (i == SLOTS - 1) begin : g_last
                assign next_e = '0;
            end else begin : g_inner
                assign next_e = entries[i+1];
            end
            stq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .prev_le    (prev_l),
                .prev_hit   (prev_h),
                .next_entry (next_e),
                .entry      (entries[i]),
                .le         (le_vec[i]),
                .hit        (hit_vec[i])
            );
            assign valid_vec[i] = entries[i].valid;
        end
    endgenerate

    assign head = entries[0];

endmodule

`default_nettype wire
